// File: rtl/md5de_pkg.sv
package md5de_pkg;

    // Padding phase of the block being compressed
    localparam logic [1:0] PH_DATA  = 2'd0;  // ordinary full message block
    localparam logic [1:0] PH_PAD1  = 2'd1;  // block holding the tail, 0x80 and maybe length
    localparam logic [1:0] PH_PAD2  = 2'd2;  // extra block of zeros and length

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;

    localparam logic [7:0] PAD_MARK = 8'h80;

    // Control from the sequencer to the message word buffer
    typedef struct packed {
        logic [1:0]  phase;
        logic [5:0]  fill;
        logic [63:0] bit_len;
    } md5de_pad_t;

    // Message word index used by round r
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] r4;
        logic [3:0] g;
        begin
            r4 = r[3:0];
            unique case (r[5:4])
                2'd0: g = r4;
                2'd1: g = 4'(5 * r4 + 1);
                2'd2: g = 4'(3 * r4 + 5);
                default: g = 4'(7 * r4);
            endcase
            return g;
        end
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] r);
        logic [4:0] s;
        begin
            unique case ({r[5:4], r[1:0]})
                4'd0:  s = 5'd7;
                4'd1:  s = 5'd12;
                4'd2:  s = 5'd17;
                4'd3:  s = 5'd22;
                4'd4:  s = 5'd5;
                4'd5:  s = 5'd9;
                4'd6:  s = 5'd14;
                4'd7:  s = 5'd20;
                4'd8:  s = 5'd4;
                4'd9:  s = 5'd11;
                4'd10: s = 5'd16;
                4'd11: s = 5'd23;
                4'd12: s = 5'd6;
                4'd13: s = 5'd10;
                4'd14: s = 5'd15;
                default: s = 5'd21;
            endcase
            return s;
        end
    endfunction

    function automatic logic [31:0] round_const(input logic [5:0] r);
        logic [31:0] k;
        begin
            unique case (r)
                6'd0:  k = 32'hd76aa478;
                6'd1:  k = 32'he8c7b756;
                6'd2:  k = 32'h242070db;
                6'd3:  k = 32'hc1bdceee;
                6'd4:  k = 32'hf57c0faf;
                6'd5:  k = 32'h4787c62a;
                6'd6:  k = 32'ha8304613;
                6'd7:  k = 32'hfd469501;
                6'd8:  k = 32'h698098d8;
                6'd9:  k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1;
                6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122;
                6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e;
                6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562;
                6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51;
                6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d;
                6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681;
                6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6;
                6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87;
                6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905;
                6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9;
                6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942;
                6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122;
                6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44;
                6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60;
                6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6;
                6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085;
                6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039;
                6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8;
                6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244;
                6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7;
                6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3;
                6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d;
                6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f;
                6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314;
                6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82;
                6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb;
                default: k = 32'heb86d391;
            endcase
            return k;
        end
    endfunction

endpackage

// File: rtl/md5de_round.sv
// One MD5 step: new b from a, b, c, d, the message word and the round number
module md5de_round (
    input  logic [5:0]  rnd,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] c,
    input  logic [31:0] d,
    input  logic [31:0] m,
    output logic [31:0] b_new
);

    logic [31:0] f;
    logic [31:0] sum;
    logic [63:0] rot_dbl;
    logic [4:0]  s;

    always_comb
    begin
        case (rnd[5:4])
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & d) | (c & ~d);
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        s       = md5de_pkg::rot_amount(rnd);
        sum     = a + f + md5de_pkg::round_const(rnd) + m;
        rot_dbl = {sum, sum} << s;
        b_new   = b + rot_dbl[63:32];
    end

endmodule

// File: rtl/md5de_msgbuf.sv
// Block buffer as 16 little-endian words; read word is masked into padding on the fly
module md5de_msgbuf (
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [5:0]             wr_pos,
    input  logic [7:0]             wr_byte,
    input  logic [3:0]             rd_addr,
    input  md5de_pkg::md5de_pad_t  pad,
    output logic [31:0]            word
);

    logic [31:0] mem [16];
    logic [31:0] mem_q;
    logic [3:0]  addr_q;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_pos[5:2]][wr_pos[1:0]*8 +: 8] <= wr_byte;
        end
        mem_q  <= mem[rd_addr];
        addr_q <= rd_addr;
    end

    always_comb
    begin
        logic [5:0] p;
        logic       fill_hi;
        fill_hi = (pad.fill[5:3] == 3'd7);
        for (int j = 0; j < 4; j++)
        begin
            p = {addr_q, 2'(j)};
            case (pad.phase)
                md5de_pkg::PH_PAD1:
                begin
                    if (p < pad.fill)
                        word[j*8 +: 8] = mem_q[j*8 +: 8];
                    else if (p == pad.fill)
                        word[j*8 +: 8] = md5de_pkg::PAD_MARK;
                    else if (!fill_hi && p[5:3] == 3'd7)
                        word[j*8 +: 8] = pad.bit_len[{p[2:0], 3'b000} +: 8];
                    else
                        word[j*8 +: 8] = 8'h00;
                end
                md5de_pkg::PH_PAD2:
                begin
                    if (p[5:3] == 3'd7)
                        word[j*8 +: 8] = pad.bit_len[{p[2:0], 3'b000} +: 8];
                    else
                        word[j*8 +: 8] = 8'h00;
                end
                default:
                    word[j*8 +: 8] = mem_q[j*8 +: 8];
            endcase
        end
    end

endmodule

// File: rtl/md5de_ctrl.sv
// Sequencer: byte intake, 64-round compression, chaining update, digest output
module md5de_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             in_byte,
    input  logic                   in_has_byte,
    input  logic                   in_end,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [31:0]            out_word,
    output logic [1:0]             out_index,
    output logic                   out_last,
    output logic                   wr_en,
    output logic [5:0]             wr_pos,
    output logic [7:0]             wr_byte,
    output logic [3:0]             rd_addr,
    output md5de_pkg::md5de_pad_t  pad,
    input  logic [31:0]            msg_word
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_FOLD  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] count_reg, count_next;
    logic [1:0]  phase_reg, phase_next;
    logic        eom_reg, eom_next;
    logic [1:0]  idx_reg, idx_next;
    logic [31:0] h_reg [4];
    logic [31:0] h_next [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] a_next, b_next, c_next, d_next;
    logic [31:0] b_round;
    logic        in_xfer, out_xfer;

    md5de_round u_round (
        .rnd   (rnd_reg),
        .a     (a_reg),
        .b     (b_reg),
        .c     (c_reg),
        .d     (d_reg),
        .m     (msg_word),
        .b_new (b_round)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign in_xfer   = in_valid && in_ready;
    assign out_xfer  = out_valid && out_ready;
    assign out_word  = h_reg[idx_reg];
    assign out_index = idx_reg;
    assign out_last  = (idx_reg == 2'd3);

    assign wr_en   = in_xfer && in_has_byte;
    assign wr_pos  = fill_reg;
    assign wr_byte = in_byte;
    // fetch one round ahead; data is registered in the buffer
    assign rd_addr = md5de_pkg::msg_index((state_reg == ST_ROUND) ? 6'(rnd_reg + 6'd1) : 6'd0);

    assign pad.phase   = phase_reg;
    assign pad.fill    = fill_reg;
    assign pad.bit_len = {count_reg, 3'b000};

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        fill_next  = fill_reg;
        count_next = count_reg;
        phase_next = phase_reg;
        eom_next   = eom_reg;
        idx_next   = idx_reg;
        h_next     = h_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (in_has_byte)
                    begin
                        fill_next  = 6'(fill_reg + 6'd1);
                        count_next = 61'(count_reg + 61'd1);
                        if (fill_reg == 6'd63)
                        begin
                            eom_next   = in_end;
                            phase_next = md5de_pkg::PH_DATA;
                            state_next = ST_PREP;
                        end
                        else if (in_end)
                        begin
                            phase_next = md5de_pkg::PH_PAD1;
                            state_next = ST_PREP;
                        end
                    end
                    else if (in_end)
                    begin
                        phase_next = md5de_pkg::PH_PAD1;
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                a_next     = h_reg[0];
                b_next     = h_reg[1];
                c_next     = h_reg[2];
                d_next     = h_reg[3];
                rnd_next   = 6'd0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                a_next   = d_reg;
                b_next   = b_round;
                c_next   = b_reg;
                d_next   = c_reg;
                rnd_next = 6'(rnd_reg + 6'd1);
                if (rnd_reg == 6'd63)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                h_next[0] = h_reg[0] + a_reg;
                h_next[1] = h_reg[1] + b_reg;
                h_next[2] = h_reg[2] + c_reg;
                h_next[3] = h_reg[3] + d_reg;
                if (phase_reg == md5de_pkg::PH_DATA)
                begin
                    if (eom_reg)
                    begin
                        eom_next   = 1'b0;
                        phase_next = md5de_pkg::PH_PAD1;
                        state_next = ST_PREP;
                    end
                    else
                        state_next = ST_IDLE;
                end
                else if (phase_reg == md5de_pkg::PH_PAD1 && fill_reg[5:3] == 3'd7)
                begin
                    phase_next = md5de_pkg::PH_PAD2;
                    state_next = ST_PREP;
                end
                else
                begin
                    idx_next   = 2'd0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_xfer)
                begin
                    idx_next = 2'(idx_reg + 2'd1);
                    if (idx_reg == 2'd3)
                    begin
                        h_next[0]  = md5de_pkg::H0_INIT;
                        h_next[1]  = md5de_pkg::H1_INIT;
                        h_next[2]  = md5de_pkg::H2_INIT;
                        h_next[3]  = md5de_pkg::H3_INIT;
                        fill_next  = 6'd0;
                        count_next = 61'd0;
                        phase_next = md5de_pkg::PH_DATA;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rnd_reg   <= 6'd0;
            fill_reg  <= 6'd0;
            count_reg <= 61'd0;
            phase_reg <= md5de_pkg::PH_DATA;
            eom_reg   <= 1'b0;
            idx_reg   <= 2'd0;
            h_reg[0]  <= md5de_pkg::H0_INIT;
            h_reg[1]  <= md5de_pkg::H1_INIT;
            h_reg[2]  <= md5de_pkg::H2_INIT;
            h_reg[3]  <= md5de_pkg::H3_INIT;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            fill_reg  <= fill_next;
            count_reg <= count_next;
            phase_reg <= phase_next;
            eom_reg   <= eom_next;
            idx_reg   <= idx_next;
            h_reg     <= h_next;
        end
    end

    // working variables carry no reset
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
    end

endmodule

// File: rtl/md5_digest_engine.sv
// MD5 digest engine over a byte stream.
// Input channel (s_axis): one transfer per item. tdata carries the message byte,
// tuser says whether that byte belongs to the message, tlast closes the message
// after this transfer's byte (tlast with tuser low hashes what is held so far,
// an empty message included). A transfer with tuser and tlast both low does nothing.
// Output channel (m_axis): four transfers per closed message, h0 to h3 in order;
// tuser gives the word index, tlast marks h3. Digest bytes are each word's bytes,
// least significant first.
// A byte that does not complete a 64-byte block is written to the buffer. Each
// compression is one prefetch, 64 rounds through the single round unit and one
// chaining add. Closing a message costs one or two compressions (two when 56 or
// more bytes are in the last block), then the four words follow, one per cycle
// without stall.
// s_axis_tready is low while a compression runs or the digest is being sent.
// A stalled receiver holds the current word; no input is taken until h3 goes.
// Reset (rst_n low, asynchronous) loads the initial chaining words, clears the
// fill and byte counts, and returns to idle; the same happens after each digest.
module md5_digest_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] byte_valid
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [1:0]  m_axis_tuser,   // [1:0] word_index
    output logic        m_axis_tlast    // last_word
);

    logic                  wr_en;
    logic [5:0]            wr_pos;
    logic [7:0]            wr_byte;
    logic [3:0]            rd_addr;
    md5de_pkg::md5de_pad_t pad;
    logic [31:0]           msg_word;

    md5de_msgbuf u_msgbuf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_pos  (wr_pos),
        .wr_byte (wr_byte),
        .rd_addr (rd_addr),
        .pad     (pad),
        .word    (msg_word)
    );

    md5de_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_byte     (s_axis_tdata),
        .in_has_byte (s_axis_tuser),
        .in_end      (s_axis_tlast),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_word    (m_axis_tdata),
        .out_index   (m_axis_tuser),
        .out_last    (m_axis_tlast),
        .wr_en       (wr_en),
        .wr_pos      (wr_pos),
        .wr_byte     (wr_byte),
        .rd_addr     (rd_addr),
        .pad         (pad),
        .msg_word    (msg_word)
    );

endmodule
